// ===== rtl/rgb_cross_sharpen_with_luma_histogram_assert.svh =====
// Assertion helpers shared by the sharpen/histogram RTL.
// Each expands to one labeled concurrent assertion, clocked on the rising edge
// and switched off while the synchronous reset is high.
`ifndef RGB_CROSS_SHARPEN_WITH_LUMA_HISTOGRAM_ASSERT_SVH
`define RGB_CROSS_SHARPEN_WITH_LUMA_HISTOGRAM_ASSERT_SVH

// Same-cycle implication.
`define RCS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define RCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rcs_pkg.sv =====
`default_nettype none

package rcs_pkg;

   localparam int CHAN_W      = 8;
   localparam int CNT_W       = 23;
   localparam int NUM_BINS    = 5;
   localparam int TOTAL_W     = CNT_W + 3;
   localparam int FW_W        = 12;
   localparam int FH_W        = 13;
   localparam int CSR_DATA_W  = 13;
   localparam int CSR_INDEX_W = 1;
   localparam int LUMA_W      = 22;

   // register map
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

   localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 12'd640;
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;

   // word kinds on the request channel
   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   localparam logic [CNT_W-1:0] BIN_MAX = '1;

   // luma * 10000, rounded boundaries at 50.5, 101.5, 152.5, 203.5
   localparam logic [LUMA_W-1:0] LUMA_R_COEF = 22'd2126;
   localparam logic [LUMA_W-1:0] LUMA_G_COEF = 22'd7152;
   localparam logic [LUMA_W-1:0] LUMA_B_COEF = 22'd722;
   localparam logic [LUMA_W-1:0] LUMA_T0     = 22'd505000;
   localparam logic [LUMA_W-1:0] LUMA_T1     = 22'd1015000;
   localparam logic [LUMA_W-1:0] LUMA_T2     = 22'd1525000;
   localparam logic [LUMA_W-1:0] LUMA_T3     = 22'd2035000;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   // centre and its four cross neighbors
   typedef struct packed {
      pixel_type ctr;
      pixel_type lft;
      pixel_type rgt;
      pixel_type up;
      pixel_type dn;
   } window_type;

   typedef struct packed {
      logic use_kernel;
      logic clear_bins;
      logic frame_end;
   } emit_ctrl_type;

   // 5*c - l - r - u - d, clamped to 0..255
   function automatic logic [CHAN_W-1:0] sharpen_chan(
      input logic [CHAN_W-1:0] c,
      input logic [CHAN_W-1:0] l,
      input logic [CHAN_W-1:0] r,
      input logic [CHAN_W-1:0] u,
      input logic [CHAN_W-1:0] d
   );
      logic [CHAN_W+2:0] five_c;
      logic [CHAN_W+1:0] nsum;
      logic [CHAN_W+2:0] diff;
      logic [CHAN_W-1:0] res;
      five_c = {c, 2'b00} + {3'b000, c};
      nsum   = {2'b00, l} + {2'b00, r} + {2'b00, u} + {2'b00, d};
      diff   = five_c - {1'b0, nsum};
      if ({1'b0, nsum} > five_c) begin
         res = '0;
      end else if (diff[CHAN_W+2:CHAN_W] != 3'b000) begin
         res = '1;
      end else begin
         res = diff[CHAN_W-1:0];
      end
      return res;
   endfunction

   // one-hot histogram bin of a pixel's luma
   function automatic logic [NUM_BINS-1:0] luma_bin(input pixel_type p);
      logic [LUMA_W-1:0]   s;
      logic [NUM_BINS-1:0] b;
      s = LUMA_R_COEF * LUMA_W'(p.red) + LUMA_G_COEF * LUMA_W'(p.green)
        + LUMA_B_COEF * LUMA_W'(p.blue);
      b = '0;
      if (s < LUMA_T0) begin
         b[0] = 1'b1;
      end else if (s < LUMA_T1) begin
         b[1] = 1'b1;
      end else if (s < LUMA_T2) begin
         b[2] = 1'b1;
      end else if (s < LUMA_T3) begin
         b[3] = 1'b1;
      end else begin
         b[4] = 1'b1;
      end
      return b;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/rcs_pixel_pipe.sv =====
`default_nettype none
`include "rgb_cross_sharpen_with_luma_histogram_assert.svh"

// Sharpen -> luma bin -> counter/output register. Each stage moves on when
// the one ahead is empty or moving.
module rcs_pixel_pipe (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         win_valid,
   output logic                         win_ready,
   input  rcs_pkg::window_type          win,
   input  rcs_pkg::emit_ctrl_type       ctrl,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [rcs_pkg::CHAN_W-1:0]   rsp_out_red,
   output logic [rcs_pkg::CHAN_W-1:0]   rsp_out_green,
   output logic [rcs_pkg::CHAN_W-1:0]   rsp_out_blue,
   output logic                         rsp_frame_end,
   output logic [rcs_pkg::CNT_W-1:0]    rsp_bin0_count,
   output logic [rcs_pkg::CNT_W-1:0]    rsp_bin1_count,
   output logic [rcs_pkg::CNT_W-1:0]    rsp_bin2_count,
   output logic [rcs_pkg::CNT_W-1:0]    rsp_bin3_count,
   output logic [rcs_pkg::CNT_W-1:0]    rsp_bin4_count
);
   import rcs_pkg::*;

   logic                s2_v_ff, s2_v_in;
   pixel_type           s2_pix_ff, s2_pix_in;
   logic                s2_clear_ff, s2_end_ff;

   logic                s3_v_ff, s3_v_in;
   pixel_type           s3_pix_ff;
   logic [NUM_BINS-1:0] s3_bin_ff, s3_bin_in;
   logic                s3_clear_ff, s3_end_ff;

   logic                out_v_ff, out_v_in;
   pixel_type           out_pix_ff;
   logic                out_end_ff;
   logic [CNT_W-1:0]    bin_cnt_ff [NUM_BINS];
   logic [CNT_W-1:0]    bin_cnt_in [NUM_BINS];
   logic [TOTAL_W-1:0]  cnt_total;

   logic out_ready, s3_ready, s2_ready;
   logic s2_load, s3_load, out_load;

   assign out_ready = ~out_v_ff | ~rsp_stall;
   assign s3_ready  = ~s3_v_ff | out_ready;
   assign s2_ready  = ~s2_v_ff | s3_ready;
   assign win_ready = s2_ready;

   assign s2_load  = win_valid & s2_ready;
   assign s3_load  = s2_v_ff & s3_ready;
   assign out_load = s3_v_ff & out_ready;

   assign s2_v_in  = s2_load | (s2_v_ff & ~s3_load);
   assign s3_v_in  = s3_load | (s3_v_ff & ~out_load);
   assign out_v_in = out_load | (out_v_ff & rsp_stall);

   always_comb begin
      if (ctrl.use_kernel) begin
         s2_pix_in.red   = sharpen_chan(win.ctr.red, win.lft.red, win.rgt.red,
                                        win.up.red, win.dn.red);
         s2_pix_in.green = sharpen_chan(win.ctr.green, win.lft.green, win.rgt.green,
                                        win.up.green, win.dn.green);
         s2_pix_in.blue  = sharpen_chan(win.ctr.blue, win.lft.blue, win.rgt.blue,
                                        win.up.blue, win.dn.blue);
      end else begin
         s2_pix_in = win.ctr;
      end
   end

   assign s3_bin_in = luma_bin(s2_pix_ff);

   // saturating counters; a frame's first pixel restarts them
   always_comb begin
      logic [CNT_W-1:0] base;
      for (int k = 0; k < NUM_BINS; k++) begin
         base = s3_clear_ff ? '0 : bin_cnt_ff[k];
         if (s3_bin_ff[k] && (base != BIN_MAX)) begin
            base = base + CNT_W'(1);
         end
         bin_cnt_in[k] = out_load ? base : bin_cnt_ff[k];
      end
   end

   always_comb begin
      cnt_total = '0;
      for (int k = 0; k < NUM_BINS; k++) begin
         cnt_total = cnt_total + TOTAL_W'(bin_cnt_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         for (int k = 0; k < NUM_BINS; k++) begin
            bin_cnt_ff[k] <= '0;
         end
      end else begin
         s2_v_ff  <= s2_v_in;
         s3_v_ff  <= s3_v_in;
         out_v_ff <= out_v_in;
         for (int k = 0; k < NUM_BINS; k++) begin
            bin_cnt_ff[k] <= bin_cnt_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_pix_ff   <= s2_pix_in;
         s2_clear_ff <= ctrl.clear_bins;
         s2_end_ff   <= ctrl.frame_end;
      end
      if (s3_load) begin
         s3_pix_ff   <= s2_pix_ff;
         s3_bin_ff   <= s3_bin_in;
         s3_clear_ff <= s2_clear_ff;
         s3_end_ff   <= s2_end_ff;
      end
      if (out_load) begin
         out_pix_ff <= s3_pix_ff;
         out_end_ff <= s3_end_ff;
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_out_red    = out_pix_ff.red;
   assign rsp_out_green  = out_pix_ff.green;
   assign rsp_out_blue   = out_pix_ff.blue;
   assign rsp_frame_end  = out_end_ff;
   assign rsp_bin0_count = bin_cnt_ff[0];
   assign rsp_bin1_count = bin_cnt_ff[1];
   assign rsp_bin2_count = bin_cnt_ff[2];
   assign rsp_bin3_count = bin_cnt_ff[3];
   assign rsp_bin4_count = bin_cnt_ff[4];

   `RCS_ASSERT_IMPL(a_s3_bin_onehot, clock, reset, s3_v_ff, $onehot(s3_bin_ff),
                    "luma stage holds no single bin")
   `RCS_ASSERT_NEXT(a_s2_holds, clock, reset, s2_v_ff && !s3_ready, s2_v_ff,
                    "sharpen stage dropped a word under backpressure")
   `RCS_ASSERT_NEXT(a_clear_total, clock, reset, out_load && s3_clear_ff,
                    cnt_total == TOTAL_W'(1), "histogram not restarted at frame start")

endmodule

`default_nettype wire

// ===== rtl/rgb_cross_sharpen_with_luma_histogram.sv =====
// Channel   | Ports                                       | Direction
// ----------+---------------------------------------------+-----------
// request   | req_valid, req_stall, req_cmd, req_in_*     | in (stall out)
// response  | rsp_valid, rsp_stall, rsp_out_*, frame_end, | out (stall in)
//           | rsp_bin0..4_count                           |
// config    | csr_write_enable, csr_index, csr_write_data | in
//
// One request word per clock while req_stall is low; the ring reads happen at the
// accept edge, so pixel and drain words alike are taken at that rate.
// A released output passes the ring read register, loaded at the accept edge of
// the word that releases it, then the sharpen, luma bin and counter/output
// registers before it can be taken.
// Reset is synchronous; the pixel ring is not cleared (entries are read only
// after they are written), so the block is ready the cycle after reset.
// req_stall rises only when the read register and all three pipe stages are
// full and rsp_stall holds the output word.
`default_nettype none
`include "rgb_cross_sharpen_with_luma_histogram_assert.svh"

module rgb_cross_sharpen_with_luma_histogram #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_cmd,
   input  logic [rcs_pkg::CHAN_W-1:0]       req_in_red,
   input  logic [rcs_pkg::CHAN_W-1:0]       req_in_green,
   input  logic [rcs_pkg::CHAN_W-1:0]       req_in_blue,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [rcs_pkg::CHAN_W-1:0]       rsp_out_red,
   output logic [rcs_pkg::CHAN_W-1:0]       rsp_out_green,
   output logic [rcs_pkg::CHAN_W-1:0]       rsp_out_blue,
   output logic                             rsp_frame_end,
   output logic [rcs_pkg::CNT_W-1:0]        rsp_bin0_count,
   output logic [rcs_pkg::CNT_W-1:0]        rsp_bin1_count,
   output logic [rcs_pkg::CNT_W-1:0]        rsp_bin2_count,
   output logic [rcs_pkg::CNT_W-1:0]        rsp_bin3_count,
   output logic [rcs_pkg::CNT_W-1:0]        rsp_bin4_count,
   input  logic                             csr_write_enable,
   input  logic [rcs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [rcs_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import rcs_pkg::*;

   // The ring holds the last 2*MAX_WIDTH+2 pixels: both line stores and the
   // window in one circular buffer, so any delay the stream ends up with
   // (after a geometry change) still finds its neighbors.
   localparam int RD = 2 * MAX_WIDTH + 2;
   localparam int AW = $clog2(RD);
   localparam int PW = $clog2(MAX_WIDTH + 3);   // pending count 0..MAX_WIDTH+2
   localparam int WW = $clog2(MAX_WIDTH + 1);   // effective width
   localparam int HW = $clog2(MAX_HEIGHT + 1);  // effective height
   localparam int CW = $clog2(MAX_WIDTH);       // column index
   localparam int RW = $clog2(MAX_HEIGHT);      // row index

   localparam logic [AW:0]   RD_V     = (AW + 1)'(RD);
   localparam logic [AW-1:0] WP_LAST  = AW'(RD - 1);
   localparam logic [PW-1:0] PEND_MAX = PW'(MAX_WIDTH + 2);

   // config registers
   logic [FW_W-1:0] frame_width_ff, frame_width_in;
   logic [FH_W-1:0] frame_height_ff, frame_height_in;
   logic [WW-1:0]   eff_w;
   logic [HW-1:0]   eff_h;

   // stream state
   logic [AW-1:0] wp_ff, wp_in;
   logic [PW-1:0] pend_ff, pend_in;
   logic [CW-1:0] in_col_ff, in_col_in;
   logic [RW-1:0] in_row_ff, in_row_in;
   logic [CW-1:0] out_col_ff, out_col_in;
   logic [RW-1:0] out_row_ff, out_row_in;

   logic          accept, is_pix, emit;
   logic [PW-1:0] pend_inc, pend_sel, lag;
   logic          interior, has_rows;
   emit_ctrl_type s1_ctrl_in, s1_ctrl_ff;
   logic          s1_v_ff, s1_v_in, s1_load;
   logic          win_ready;

   logic [AW-1:0] base;
   logic [AW-1:0] kc, kl, kr, ku, kd, kw;
   logic [AW-1:0] addr_c, addr_l, addr_r, addr_u, addr_d;

   pixel_type     req_pix;
   pixel_type     mem_a [RD];
   pixel_type     mem_b [RD];
   pixel_type     mem_c [RD];
   window_type    s1_win_ff;

   // ring index k pixels back from base
   function automatic logic [AW-1:0] ring_back(
      input logic [AW-1:0] b,
      input logic [AW-1:0] k
   );
      logic [AW:0] t;
      t = {1'b0, b} + RD_V - {1'b0, k};
      if (t >= RD_V) begin
         t = t - RD_V;
      end
      return t[AW-1:0];
   endfunction

   assign req_pix = {req_in_red, req_in_green, req_in_blue};
   assign accept  = req_valid & ~req_stall;
   assign is_pix  = (req_cmd == CMD_PIXEL);

   // --- configuration ---------------------------------------------------
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_FRAME_WIDTH:  frame_width_in  = csr_write_data[FW_W-1:0];
            REG_FRAME_HEIGHT: frame_height_in = csr_write_data[FH_W-1:0];
            default: ;
         endcase
      end
   end

   // out-of-range geometry is clamped to 3..MAX
   always_comb begin
      if (frame_width_ff < FW_W'(3)) begin
         eff_w = WW'(3);
      end else if (32'(frame_width_ff) > MAX_WIDTH) begin
         eff_w = WW'(MAX_WIDTH);
      end else begin
         eff_w = WW'(frame_width_ff);
      end
      if (frame_height_ff < FH_W'(3)) begin
         eff_h = HW'(3);
      end else if (32'(frame_height_ff) > MAX_HEIGHT) begin
         eff_h = HW'(MAX_HEIGHT);
      end else begin
         eff_h = HW'(frame_height_ff);
      end
   end

   // --- per-word bookkeeping ---------------------------------------------
   // A pixel adds one pending entry (saturating) and releases the oldest
   // once width+2 are held. A drain releases one only at the top-left input
   // position with something pending. The released pixel sits lag entries
   // back from the newest ring entry.
   always_comb begin
      pend_inc = (pend_ff < PEND_MAX) ? pend_ff + PW'(1) : pend_ff;
      pend_sel = is_pix ? pend_inc : pend_ff;
      lag      = pend_sel - PW'(1);
      if (is_pix) begin
         emit = (pend_inc >= PW'(eff_w) + PW'(2));
      end else begin
         emit = (in_col_ff == '0) && (in_row_ff == '0) && (pend_ff != '0);
      end
      pend_in = accept ? (emit ? lag : pend_sel) : pend_ff;
   end

   // input raster position, advanced by pixels only
   always_comb begin
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      if (accept && is_pix) begin
         if ((WW'(in_col_ff) + WW'(1)) >= eff_w) begin
            in_col_in = '0;
            if ((HW'(in_row_ff) + HW'(1)) >= eff_h) begin
               in_row_in = '0;
            end else begin
               in_row_in = in_row_ff + RW'(1);
            end
         end else begin
            in_col_in = in_col_ff + CW'(1);
         end
      end
   end

   // output raster position, advanced by every released pixel
   always_comb begin
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (accept && emit) begin
         if ((WW'(out_col_ff) + WW'(1)) >= eff_w) begin
            out_col_in = '0;
            if ((HW'(out_row_ff) + HW'(1)) >= eff_h) begin
               out_row_in = '0;
            end else begin
               out_row_in = out_row_ff + RW'(1);
            end
         end else begin
            out_col_in = out_col_ff + CW'(1);
         end
      end
   end

   // Kernel only on interior pixels whose lower row is already in the ring;
   // otherwise the centre passes through.
   always_comb begin
      interior = (out_row_ff != '0) && (HW'(out_row_ff) < eff_h - HW'(1)) &&
                 (out_col_ff != '0) && (WW'(out_col_ff) < eff_w - WW'(1));
      has_rows = (lag >= PW'(eff_w));
      s1_ctrl_in.use_kernel = interior && has_rows;
      s1_ctrl_in.clear_bins = (out_row_ff == '0) && (out_col_ff == '0);
      s1_ctrl_in.frame_end  = (HW'(out_row_ff) >= eff_h - HW'(1)) &&
                              (WW'(out_col_ff) >= eff_w - WW'(1));
   end

   // Ring addresses. For a pixel the newest entry is the one written now
   // (at wp); for a drain it is the last one written. A pixel never reads
   // its own slot, so write and reads never collide.
   always_comb begin
      if (is_pix) begin
         base = wp_ff;
      end else if (wp_ff == '0) begin
         base = WP_LAST;
      end else begin
         base = wp_ff - AW'(1);
      end
      kw = AW'(eff_w);
      kc = AW'(lag);
      kl = kc + AW'(1);
      kr = (kc == '0) ? '0 : kc - AW'(1);
      ku = kc + kw;
      kd = has_rows ? kc - kw : '0;
      addr_c = ring_back(base, kc);
      addr_l = ring_back(base, kl);
      addr_r = ring_back(base, kr);
      addr_u = ring_back(base, ku);
      addr_d = ring_back(base, kd);
   end

   always_comb begin
      wp_in = wp_ff;
      if (accept && is_pix) begin
         wp_in = (wp_ff == WP_LAST) ? '0 : wp_ff + AW'(1);
      end
   end

   // --- read stage -------------------------------------------------------
   assign s1_load   = accept & emit;
   assign s1_v_in   = s1_load | (s1_v_ff & ~win_ready);
   assign req_stall = s1_v_ff & ~win_ready;

   // Three copies of the ring, each written with every pixel, give five
   // read ports (two, two, one).
   always_ff @(posedge clock) begin
      if (accept && is_pix) begin
         mem_a[wp_ff] <= req_pix;
         mem_b[wp_ff] <= req_pix;
         mem_c[wp_ff] <= req_pix;
      end
      if (s1_load) begin
         s1_win_ff.ctr <= mem_a[addr_c];
         s1_win_ff.lft <= mem_a[addr_l];
         s1_win_ff.rgt <= mem_b[addr_r];
         s1_win_ff.up  <= mem_b[addr_u];
         s1_win_ff.dn  <= mem_c[addr_d];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_ctrl_ff <= s1_ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
         wp_ff           <= '0;
         pend_ff         <= '0;
         in_col_ff       <= '0;
         in_row_ff       <= '0;
         out_col_ff      <= '0;
         out_row_ff      <= '0;
         s1_v_ff         <= 1'b0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         wp_ff           <= wp_in;
         pend_ff         <= pend_in;
         in_col_ff       <= in_col_in;
         in_row_ff       <= in_row_in;
         out_col_ff      <= out_col_in;
         out_row_ff      <= out_row_in;
         s1_v_ff         <= s1_v_in;
      end
   end

   // --- sharpen, histogram and output register ----------------------------
   rcs_pixel_pipe u_pipe (
      .clock          (clock),
      .reset          (reset),
      .win_valid      (s1_v_ff),
      .win_ready      (win_ready),
      .win            (s1_win_ff),
      .ctrl           (s1_ctrl_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_frame_end  (rsp_frame_end),
      .rsp_bin0_count (rsp_bin0_count),
      .rsp_bin1_count (rsp_bin1_count),
      .rsp_bin2_count (rsp_bin2_count),
      .rsp_bin3_count (rsp_bin3_count),
      .rsp_bin4_count (rsp_bin4_count)
   );

   `RCS_ASSERT_IMPL(a_wp_range, clock, reset, 1'b1, wp_ff <= WP_LAST,
                    "ring write pointer out of range")
   `RCS_ASSERT_NEXT(a_drain_keeps_wp, clock, reset, accept && !is_pix,
                    wp_ff == $past(wp_ff), "drain word moved the ring write pointer")
   `RCS_ASSERT_NEXT(a_emit_keeps_pend, clock, reset,
                    accept && is_pix && emit && (pend_ff != PEND_MAX),
                    pend_ff == $past(pend_ff), "pixel in and out changed the pending count")

endmodule

`default_nettype wire
